FILE: hw/rtl/rpks_pkg.sv
// ----------------------------------------------------------------------------
// rpks_pkg: shared types and constants for the polar k-strongest block
// Default sizes, CORDIC constants and the command/status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rpks_pkg;

  // default sizes
  localparam int MAX_KEEP_DEF   = 64;
  localparam int AZIMUTHS_DEF   = 400;
  localparam int RANGE_BINS_DEF = 4096;

  // widest azimuth count and range bin count, plus one bit for compares
  localparam int AZ_CW = 13;

  // CORDIC: 16 rotations in Q2.30, angles in 1/2^24 turn
  localparam int                 CORDIC_STEPS = 16;
  localparam int                 CORDIC_IW    = 4;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

  // top list entry: {intensity, y, x}
  localparam int ENTRY_W = 40;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESH = 3'd0;
  localparam logic [2:0] CFG_KEEP   = 3'd1;
  localparam logic [2:0] CFG_FIRST  = 3'd2;
  localparam logic [2:0] CFG_STEP   = 3'd3;
  localparam logic [2:0] CFG_LIMIT  = 3'd4;

  // arctangent of 2^-s, in 1/2^24 turn
  function automatic logic signed [25:0] atan_turn(input logic [CORDIC_IW-1:0] s);
    logic signed [25:0] a;
    case (s)
      4'd0:    a = 26'sd2097152;
      4'd1:    a = 26'sd1238021;
      4'd2:    a = 26'sd654136;
      4'd3:    a = 26'sd332050;
      4'd4:    a = 26'sd166669;
      4'd5:    a = 26'sd83416;
      4'd6:    a = 26'sd41718;
      4'd7:    a = 26'sd20860;
      4'd8:    a = 26'sd10430;
      4'd9:    a = 26'sd5215;
      4'd10:   a = 26'sd2608;
      4'd11:   a = 26'sd1304;
      4'd12:   a = 26'sd652;
      4'd13:   a = 26'sd326;
      4'd14:   a = 26'sd163;
      default: a = 26'sd81;
    endcase
    return a;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 div_step;
    logic                 cord_init;
    logic                 cord_step;
    logic [CORDIC_IW-1:0] cord_idx;
    logic                 mul1;
    logic                 mul2;
    logic                 rnd;
    logic                 ins_start;
    logic                 rd_last;
    logic                 rd_prev;
    logic                 wr_new;
    logic                 wr_shift;
    logic                 emit_init;
    logic                 emit_rd;
    logic                 emit_ld;
    logic                 clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass;
    logic xy_ok;
    logic full;
    logic k_zero;
    logic stays;
    logic emit_done;
    logic out_busy;
    logic col_end;
  } sts_t;

endpackage

FILE: hw/rtl/rpks_ram.sv
// ----------------------------------------------------------------------------
// rpks_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rpks_ctrl.sv
// ----------------------------------------------------------------------------
// rpks_ctrl: sequencer for the polar k-strongest block
// Steps one pixel through filter, phase divide, CORDIC, scaling, list
// insertion and, at column end, the emit sweep.
// ----------------------------------------------------------------------------
module rpks_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rpks_pkg::sts_t sts,
  output rpks_pkg::cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_FILT     = 17'h00002,
    S_DIV      = 17'h00004,
    S_CINIT    = 17'h00008,
    S_CORD     = 17'h00010,
    S_MUL1     = 17'h00020,
    S_MUL2     = 17'h00040,
    S_RND      = 17'h00080,
    S_CHK      = 17'h00100,
    S_INS0     = 17'h00200,
    S_FULL_CMP = 17'h00400,
    S_INS_RD   = 17'h00800,
    S_INS_CMP  = 17'h01000,
    S_TAIL     = 17'h02000,
    S_EMIT_RD  = 17'h04000,
    S_EMIT_LD  = 17'h08000,
    S_SPARE    = 17'h10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.cord_idx = cnt_r[rpks_pkg::CORDIC_IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        cnt_nxt   = '0;
        state_nxt = sts.pass ? S_DIV : S_TAIL;
      end
      // azimuth phase: three pipelined reciprocal multiply steps
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          state_nxt = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == 5'(rpks_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = sts.xy_ok ? S_INS0 : S_TAIL;
      end
      // full list: check the last entry first
      S_INS0: begin
        if (sts.full) begin
          cmd.rd_last = 1'b1;
          state_nxt   = S_FULL_CMP;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = S_INS_RD;
        end
      end
      S_FULL_CMP: begin
        if (sts.stays) begin
          state_nxt = S_TAIL;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = S_INS_RD;
        end
      end
      // walk the hole upward from the tail
      S_INS_RD: begin
        if (sts.k_zero) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_TAIL;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.stays) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_TAIL;
        end else begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_INS_RD;
        end
      end
      S_TAIL: begin
        if (sts.col_end) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (sts.emit_done) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = S_EMIT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rpks_dp.sv
// ----------------------------------------------------------------------------
// rpks_dp: datapath of the polar k-strongest block
// Config registers, phase divider, CORDIC, coordinate scaling, top list RAM
// and the output register.
// ----------------------------------------------------------------------------
module rpks_dp #(
  parameter int MAX_KEEP   = rpks_pkg::MAX_KEEP_DEF,
  parameter int AZIMUTHS   = rpks_pkg::AZIMUTHS_DEF,
  parameter int RANGE_BINS = rpks_pkg::RANGE_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [7:0]         in_inten,
  input  logic [11:0]        in_bin,
  input  logic [8:0]         in_az,
  input  logic               in_end,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [7:0]         out_inten,
  output logic               out_last,
  input  rpks_pkg::cmd_t     cmd,
  output rpks_pkg::sts_t     sts
);

  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int FW = $clog2(MAX_KEEP + 1);
  localparam int AW = rpks_pkg::AZ_CW;
  localparam logic [AW-1:0] AZ_C    = AW'(AZIMUTHS);
  localparam logic [AW-1:0] BINS_C  = AW'(RANGE_BINS);
  localparam logic [FW-1:0] MAXF_C  = FW'(MAX_KEEP);
  localparam logic [6:0]    MAXK_C  = 7'(MAX_KEEP);
  localparam logic [IW-1:0] LASTI_C = IW'(MAX_KEEP - 1);
  // 2^24 = PH_Q * AZIMUTHS + PH_R; PH_M = ceil(2^34 / AZIMUTHS)
  localparam logic [22:0]   PH_Q_C  = 23'((1 << 24) / AZIMUTHS);
  localparam logic [11:0]   PH_R_C  = 12'((1 << 24) % AZIMUTHS);
  localparam logic [11:0]   PH_H_C  = 12'(AZIMUTHS / 2);
  localparam logic [32:0]   PH_M_C  =
    33'(((64'd1 << 34) + 64'(AZIMUTHS) - 64'd1) / 64'(AZIMUTHS));

  // config registers
  logic [7:0]  thresh_r;
  logic [6:0]  keep_r;
  logic [11:0] first_r;
  logic [15:0] step_r;
  logic [14:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 8'd80;
      keep_r   <= 7'd40;
      first_r  <= 12'd4;
      step_r   <= 16'd11469;
      limit_r  <= 15'd12800;
    end else if (cfg_wen) begin
      case (cfg_index)
        rpks_pkg::CFG_THRESH: thresh_r <= cfg_wdata[7:0];
        rpks_pkg::CFG_KEEP:   keep_r   <= cfg_wdata[6:0];
        rpks_pkg::CFG_FIRST:  first_r  <= cfg_wdata[11:0];
        rpks_pkg::CFG_STEP:   step_r   <= cfg_wdata;
        rpks_pkg::CFG_LIMIT:  limit_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // captured pixel
  logic [7:0]  inten_r;
  logic [11:0] bin_r;
  logic [8:0]  az_r;
  logic        end_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inten_r <= in_inten;
      bin_r   <= in_bin;
      az_r    <= in_az;
      end_r   <= in_end;
    end
  end

  assign sts.col_end = end_r;
  assign sts.pass    = ({4'd0, az_r} < AZ_C) && ({1'b0, bin_r} < BINS_C) &&
                       (bin_r >= first_r) && (inten_r >= thresh_r);

  // phase = round(az * 2^24 / AZIMUTHS)
  //       = az * PH_Q + floor((az * PH_R + AZIMUTHS / 2) / AZIMUTHS)
  // the small quotient by reciprocal multiplication, three pipelined steps
  logic [31:0] ph_t_r;
  logic [20:0] ph_m_r;
  logic [53:0] ph_p_r;
  logic [23:0] q_r;

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      ph_t_r <= {23'd0, az_r} * {9'd0, PH_Q_C};
      ph_m_r <= {12'd0, az_r} * {9'd0, PH_R_C} + {9'd0, PH_H_C};
      ph_p_r <= {33'd0, ph_m_r} * {21'd0, PH_M_C};
      q_r    <= ph_t_r[23:0] + {4'd0, ph_p_r[53:34]};
    end
  end

  // CORDIC rotation
  logic signed [33:0] cx_r, cy_r;
  logic signed [25:0] z_r;
  logic               flip_r;
  logic signed [25:0] z0;
  logic signed [33:0] dx, dy;
  logic signed [25:0] at;

  assign z0 = {{2{q_r[23]}}, q_r};
  assign dx = cy_r >>> cmd.cord_idx;
  assign dy = cx_r >>> cmd.cord_idx;
  assign at = rpks_pkg::atan_turn(cmd.cord_idx);

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      cx_r <= rpks_pkg::CORDIC_GAIN;
      cy_r <= '0;
      if (z0 > 26'sh400000) begin
        z_r    <= z0 - 26'sh800000;
        flip_r <= 1'b1;
      end else if (z0 < -26'sh400000) begin
        z_r    <= z0 + 26'sh800000;
        flip_r <= 1'b1;
      end else begin
        z_r    <= z0;
        flip_r <= 1'b0;
      end
    end else if (cmd.cord_step) begin
      if (z_r >= 0) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + at;
      end
    end
  end

  // Q2.30 to Q1.15, round half up, clamp to +-32767
  function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
    logic signed [34:0] r;
    r = (v + 35'sd16384) >>> 15;
    if (r > 35'sd32767) begin
      return 16'sd32767;
    end else if (r < -35'sd32767) begin
      return -16'sd32767;
    end
    return r[15:0];
  endfunction

  // product rounded by 23 bits, clamp to 16 bits
  function automatic logic signed [15:0] rsat(input logic signed [46:0] p);
    logic signed [46:0] r;
    r = (p + 47'sd4194304) >>> 23;
    if (r > 47'sd32767) begin
      return 16'sd32767;
    end else if (r < -47'sd32768) begin
      return -16'sd32768;
    end
    return r[15:0];
  endfunction

  logic signed [34:0] fx, fy;
  assign fx = flip_r ? -{cx_r[33], cx_r} : {cx_r[33], cx_r};
  assign fy = flip_r ? -{cy_r[33], cy_r} : {cy_r[33], cy_r};

  // scaling: distance, then distance times cos / sin
  logic [27:0]        dist_r;
  logic signed [15:0] cos_r, sin_r;
  logic signed [44:0] px_r, py_r;
  logic signed [15:0] x_r, y_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      dist_r <= {16'd0, bin_r} * {12'd0, step_r};
      cos_r  <= to_q15(fx);
      sin_r  <= to_q15(fy);
    end
    if (cmd.mul2) begin
      px_r <= 45'($signed({1'b0, dist_r})) * 45'(cos_r);
      py_r <= 45'($signed({1'b0, dist_r})) * 45'(sin_r);
    end
    if (cmd.rnd) begin
      x_r <= rsat({{2{px_r[44]}}, px_r});
      y_r <= rsat(-{{2{py_r[44]}}, py_r});
    end
  end

  logic [16:0] ax, ay;
  assign ax = x_r[15] ? 17'(-{x_r[15], x_r}) : {1'b0, x_r};
  assign ay = y_r[15] ? 17'(-{y_r[15], y_r}) : {1'b0, y_r};
  assign sts.xy_ok = (ax < {2'd0, limit_r}) && (ay < {2'd0, limit_r});

  // top list
  logic [FW-1:0]                 fill_r;
  logic [IW-1:0]                 k_r;
  logic [FW-1:0]                 e_r, ecnt_r;
  logic                          we;
  logic [IW-1:0]                 raddr;
  logic [rpks_pkg::ENTRY_W-1:0]  wdata, rdata;
  logic [6:0]                    klim, ecnt;

  assign sts.full   = (fill_r == MAXF_C);
  assign sts.k_zero = (k_r == '0);
  assign sts.stays  = (rdata[39:32] >= inten_r);

  assign we    = cmd.wr_new | cmd.wr_shift;
  assign wdata = cmd.wr_new ? {inten_r, y_r, x_r} : rdata;

  always_comb begin
    raddr = e_r[IW-1:0];
    if (cmd.rd_last) begin
      raddr = LASTI_C;
    end else if (cmd.rd_prev) begin
      raddr = k_r - IW'(1);
    end
  end

  rpks_ram #(
    .WIDTH(rpks_pkg::ENTRY_W),
    .DEPTH(MAX_KEEP)
  ) u_list (
    .clk  (clk),
    .we   (we),
    .waddr(k_r),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // emit count = min(keep, MAX_KEEP, fill)
  assign klim = (keep_r > MAXK_C) ? MAXK_C : keep_r;
  assign ecnt = (klim > 7'(fill_r)) ? 7'(fill_r) : klim;

  assign sts.emit_done = (e_r == ecnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.clear) begin
      fill_r <= '0;
    end else if (cmd.wr_new && !sts.full) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      k_r <= sts.full ? LASTI_C : fill_r[IW-1:0];
    end else if (cmd.wr_shift) begin
      k_r <= k_r - IW'(1);
    end
    if (cmd.emit_init) begin
      e_r    <= '0;
      ecnt_r <= FW'(ecnt);
    end else if (cmd.emit_ld) begin
      e_r <= e_r + FW'(1);
    end
  end

  // output register
  logic               ovalid_r;
  logic signed [15:0] ox_r, oy_r;
  logic [7:0]         oint_r;
  logic               olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      ox_r    <= rdata[15:0];
      oy_r    <= rdata[31:16];
      oint_r  <= rdata[39:32];
      olast_r <= (e_r + FW'(1)) == ecnt_r;
    end
  end

  assign sts.out_busy = ovalid_r;
  assign out_valid    = ovalid_r;
  assign out_x        = ox_r;
  assign out_y        = oy_r;
  assign out_inten    = oint_r;
  assign out_last     = olast_r;

endmodule

FILE: hw/rtl/radar_polar_k_strongest.sv
// ----------------------------------------------------------------------------
// radar_polar_k_strongest: polar radar scan to k strongest Cartesian points
// Converts each range-bin pixel to x/y, keeps a sorted list of the strongest
// points of the column and sends them out at column end.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. A pixel that fails the azimuth, bin or
// intensity test is dropped. A candidate goes through the azimuth phase
// (reciprocal multiplication by the azimuth count), the CORDIC iterations,
// scaling and the range check, then moves past each weaker list entry in
// the simple dual-port top list. On a column end the list is read out one
// point at a time, waiting while the sink stalls, and the list is emptied.
// The last point stays in the output register while the next pixel is
// accepted.
module radar_polar_k_strongest #(
  parameter int MAX_KEEP   = rpks_pkg::MAX_KEEP_DEF,
  parameter int AZIMUTHS   = rpks_pkg::AZIMUTHS_DEF,
  parameter int RANGE_BINS = rpks_pkg::RANGE_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // pixel_intensity, range_bin, azimuth_index, zero pad
  input  logic        in_tlast,  // column_end
  // point stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // point_x, point_y, point_intensity
  output logic        out_tlast  // last_of_column
);

  rpks_pkg::cmd_t     cmd;
  rpks_pkg::sts_t     sts;
  logic signed [15:0] ox, oy;
  logic [7:0]         oint;

  rpks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpks_dp #(
    .MAX_KEEP  (MAX_KEEP),
    .AZIMUTHS  (AZIMUTHS),
    .RANGE_BINS(RANGE_BINS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_inten (in_tdata[7:0]),
    .in_bin   (in_tdata[19:8]),
    .in_az    (in_tdata[28:20]),
    .in_end   (in_tlast),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_x    (ox),
    .out_y    (oy),
    .out_inten(oint),
    .out_last (out_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign out_tdata = {oint, oy, ox};

endmodule
